// File: rtl/spi_lcd_window_fill_serializer_core_assert.svh
// Assertion macros used by the serializer checker file.
`ifndef SPI_LCD_WINDOW_FILL_SERIALIZER_CORE_ASSERT_SVH
`define SPI_LCD_WINDOW_FILL_SERIALIZER_CORE_ASSERT_SVH

// Same-cycle implication, held off during reset.
`define SLWF_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, held off during reset.
`define SLWF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/slwf_pkg.sv
// Shared constants and helpers for the SPI LCD window fill serializer.
package slwf_pkg;

	// Default coordinate width
	localparam int SLWF_COORD_BITS = 9;

	// Depth of the queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// Request codes
	localparam logic [2:0] REQ_TICK = 3'd0;
	localparam logic [2:0] REQ_CMD  = 3'd1;
	localparam logic [2:0] REQ_DATA = 3'd2;
	localparam logic [2:0] REQ_WORD = 3'd3;
	localparam logic [2:0] REQ_FILL = 3'd4;

	// Panel commands
	localparam logic [7:0] CMD_COL_ADDR  = 8'h2A;
	localparam logic [7:0] CMD_ROW_ADDR  = 8'h2B;
	localparam logic [7:0] CMD_MEM_WRITE = 8'h2C;

	// Fill header byte positions, then the pixel phase
	localparam logic [3:0] HDR_COL_CMD = 4'd0;
	localparam logic [3:0] HDR_XS_HI   = 4'd1;
	localparam logic [3:0] HDR_XS_LO   = 4'd2;
	localparam logic [3:0] HDR_XE_HI   = 4'd3;
	localparam logic [3:0] HDR_XE_LO   = 4'd4;
	localparam logic [3:0] HDR_ROW_CMD = 4'd5;
	localparam logic [3:0] HDR_YS_HI   = 4'd6;
	localparam logic [3:0] HDR_YS_LO   = 4'd7;
	localparam logic [3:0] HDR_YE_HI   = 4'd8;
	localparam logic [3:0] HDR_YE_LO   = 4'd9;
	localparam logic [3:0] HDR_MEM_WR  = 4'd10;
	localparam logic [3:0] PIXEL_PHASE = 4'd11;

	// Last bit position within a byte
	localparam logic [2:0] BIT_LAST = 3'd7;

	// Header byte for a given position; coordinates arrive zero-extended
	function automatic logic [7:0] header_byte(input logic [3:0] idx,
		input logic [15:0] xs, input logic [15:0] ys,
		input logic [15:0] xe, input logic [15:0] ye);
		logic [7:0] b;
		case (idx)
			HDR_COL_CMD: b = CMD_COL_ADDR;
			HDR_XS_HI:   b = xs[15:8];
			HDR_XS_LO:   b = xs[7:0];
			HDR_XE_HI:   b = xe[15:8];
			HDR_XE_LO:   b = xe[7:0];
			HDR_ROW_CMD: b = CMD_ROW_ADDR;
			HDR_YS_HI:   b = ys[15:8];
			HDR_YS_LO:   b = ys[7:0];
			HDR_YE_HI:   b = ye[15:8];
			HDR_YE_LO:   b = ye[7:0];
			default:     b = CMD_MEM_WRITE;
		endcase
		return b;
	endfunction

endpackage

// File: rtl/spi_lcd_window_fill_serializer_core.sv
// Top level of the 4-wire SPI LCD writer with rectangle fill.
//
// Slave side: one transaction per tick. s_tuser carries the request code
// (tick, command byte, data byte, data word, fill window); s_tdata carries
// the window corners and the value. Master side: exactly one transaction
// per input transaction, in order. m_tdata carries the bit-valid flag, the
// serial bit, the byte-end flag, busy and rejected; m_tuser carries the
// D/C line and m_tlast marks the final bit of a job.
// Input reaches the output through the front queue and then the
// serializer's output register. Throughput is one transaction per cycle
// while the receiver does not stall, set by the serializer updating its job state once per pop.
// A job arriving while another runs is dropped and flagged as rejected.
// Reset empties the queue, clears the output valid flag and leaves the
// serializer idle. When the receiver stalls the output register holds,
// the serializer stops, and the two-entry queue fills before s_tready drops.
module spi_lcd_window_fill_serializer_core import slwf_pkg::*; #(
	parameter int COORD_BITS = SLWF_COORD_BITS
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      s_tvalid,
	output logic                                      s_tready,
	// x_start, y_start, x_end, y_end, value, zero fill
	input  logic [((4*COORD_BITS+16+7)/8)*8-1:0]      s_tdata,
	// req_type
	input  logic [2:0]                                s_tuser,
	output logic                                      m_tvalid,
	input  logic                                      m_tready,
	// bit_valid, sda, byte_last, busy_res, rejected, zero fill
	output logic [7:0]                                m_tdata,
	// dc
	output logic                                      m_tuser,
	output logic                                      m_tlast
);

	localparam int DATA_W = ((4*COORD_BITS+16+7)/8)*8;

	logic              item_valid;
	logic              item_ready;
	logic [2:0]        item_kind;
	logic [DATA_W-1:0] item_data;

	slwf_front #(
		.DATA_W(DATA_W)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item_kind (item_kind),
		.item_data (item_data)
	);

	slwf_back #(
		.COORD_BITS(COORD_BITS),
		.DATA_W    (DATA_W)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item_kind (item_kind),
		.item_data (item_data),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

endmodule

// File: rtl/slwf_front.sv
// Front end: classifies incoming transactions and queues them for the back end.
module slwf_front import slwf_pkg::*; #(
	parameter int DATA_W = 56
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [DATA_W-1:0] s_tdata,
	input  logic [2:0]        s_tuser,
	output logic              item_valid,
	input  logic              item_ready,
	output logic [2:0]        item_kind,
	output logic [DATA_W-1:0] item_data
);

	logic [2:0]        kind_cls;
	logic [2:0]        kind_q [QUEUE_DEPTH];
	logic [DATA_W-1:0] data_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              push;
	logic              pop;

	// Unused request codes behave as a plain tick
	always_comb begin
		if (s_tuser inside {[REQ_CMD:REQ_FILL]}) begin
			kind_cls = s_tuser;
		end else begin
			kind_cls = REQ_TICK;
		end
	end

	assign s_tready   = (count_q != QCNT_W'(QUEUE_DEPTH));
	assign item_valid = (count_q != '0);
	assign push       = s_tvalid && s_tready;
	assign pop        = item_valid && item_ready;
	assign item_kind  = kind_q[rd_ptr_q];
	assign item_data  = data_q[rd_ptr_q];

	// Queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			kind_q[wr_ptr_q] <= kind_cls;
			data_q[wr_ptr_q] <= s_tdata;
		end
	end

	// Queue pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// File: rtl/slwf_back.sv
// Back end: job state, bit serializer and output register.
module slwf_back import slwf_pkg::*; #(
	parameter int COORD_BITS = SLWF_COORD_BITS,
	parameter int DATA_W     = 56
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	input  logic [2:0]        item_kind,
	input  logic [DATA_W-1:0] item_data,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [7:0]        m_tdata,
	output logic              m_tuser,
	output logic              m_tlast
);

	// Job state
	logic                  active_q,  active_d;
	logic [2:0]            kind_q,    kind_d;
	logic [7:0]            shift_q,   shift_d;
	logic [2:0]            bit_q,     bit_d;
	logic [3:0]            hidx_q,    hidx_d;
	logic                  low_q,     low_d;
	logic [COORD_BITS-1:0] xs_q, xs_d, ys_q, ys_d, xe_q, xe_d, ye_q, ye_d;
	logic [COORD_BITS-1:0] col_q, col_d, row_q, row_d;
	logic [15:0]           word_q,    word_d;

	// Per-transaction results
	logic vld, sda, dc, last, done, rej, fin, load_hi, is_job;

	// Output register
	logic       m_tvalid_q;
	logic [7:0] m_tdata_q;
	logic       m_tuser_q;
	logic       m_tlast_q;

	logic pop;

	assign item_ready = !m_tvalid_q || m_tready;
	assign pop        = item_valid && item_ready;
	assign is_job     = (item_kind != REQ_TICK);

	// Reject or load a job, emit one bit, then step to the next byte on a byte boundary
	always_comb begin
		active_d = active_q;
		kind_d   = kind_q;
		shift_d  = shift_q;
		bit_d    = bit_q;
		hidx_d   = hidx_q;
		low_d    = low_q;
		xs_d     = xs_q;
		ys_d     = ys_q;
		xe_d     = xe_q;
		ye_d     = ye_q;
		col_d    = col_q;
		row_d    = row_q;
		word_d   = word_q;
		vld      = 1'b0;
		sda      = 1'b0;
		dc       = 1'b0;
		last     = 1'b0;
		done     = 1'b0;
		rej      = 1'b0;
		fin      = 1'b0;
		load_hi  = 1'b0;

		if (is_job && active_q) begin
			rej = 1'b1;
		end else if (is_job) begin
			kind_d   = item_kind;
			bit_d    = '0;
			hidx_d   = HDR_COL_CMD;
			low_d    = 1'b0;
			active_d = 1'b1;
			case (item_kind)
				REQ_CMD, REQ_DATA: begin
					shift_d = item_data[4*COORD_BITS +: 8];
				end
				REQ_WORD: begin
					word_d  = item_data[4*COORD_BITS +: 16];
					shift_d = item_data[4*COORD_BITS+8 +: 8];
					low_d   = 1'b1;
				end
				REQ_FILL: begin
					xs_d    = item_data[0 +: COORD_BITS];
					ys_d    = item_data[COORD_BITS +: COORD_BITS];
					xe_d    = item_data[2*COORD_BITS +: COORD_BITS];
					ye_d    = item_data[3*COORD_BITS +: COORD_BITS];
					col_d   = item_data[0 +: COORD_BITS];
					row_d   = item_data[COORD_BITS +: COORD_BITS];
					word_d  = item_data[4*COORD_BITS +: 16];
					shift_d = CMD_COL_ADDR;
				end
				default: begin
				end
			endcase
		end

		if (active_d) begin
			vld = 1'b1;
			sda = shift_d[7];
			dc  = !((kind_d == REQ_CMD) || ((kind_d == REQ_FILL) &&
				((hidx_d == HDR_COL_CMD) || (hidx_d == HDR_ROW_CMD) ||
				(hidx_d == HDR_MEM_WR))));
			last    = (bit_d == BIT_LAST);
			shift_d = {shift_d[6:0], 1'b0};
			bit_d   = bit_d + 1'b1;
			if (last) begin
				if (kind_d == REQ_WORD) begin
					if (low_d) begin
						shift_d = word_d[7:0];
						low_d   = 1'b0;
					end else begin
						fin = 1'b1;
					end
				end else if (kind_d != REQ_FILL) begin
					fin = 1'b1;
				end else if (hidx_d < HDR_MEM_WR) begin
					hidx_d  = hidx_d + 1'b1;
					shift_d = header_byte(hidx_d, 16'(xs_d), 16'(ys_d), 16'(xe_d), 16'(ye_d));
				end else begin
					if (hidx_d == HDR_MEM_WR) begin
						hidx_d = PIXEL_PHASE;
						if ((xe_d < xs_d) || (ye_d < ys_d)) begin
							fin = 1'b1;
						end else begin
							load_hi = 1'b1;
						end
					end else if (low_d) begin
						shift_d = word_d[7:0];
						low_d   = 1'b0;
					end else if (col_d < xe_d) begin
						col_d   = col_d + 1'b1;
						load_hi = 1'b1;
					end else if (row_d < ye_d) begin
						row_d   = row_d + 1'b1;
						col_d   = xs_d;
						load_hi = 1'b1;
					end else begin
						fin = 1'b1;
					end
					if (load_hi) begin
						shift_d = word_d[15:8];
						low_d   = 1'b1;
					end
				end
				if (fin) begin
					done     = 1'b1;
					active_d = 1'b0;
				end
			end
		end
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q   <= 1'b0;
			kind_q     <= REQ_TICK;
			bit_q      <= '0;
			hidx_q     <= HDR_COL_CMD;
			low_q      <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (pop) begin
				active_q <= active_d;
				kind_q   <= kind_d;
				bit_q    <= bit_d;
				hidx_q   <= hidx_d;
				low_q    <= low_d;
			end
			if (pop) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// Datapath and output payload
	always_ff @(posedge clk) begin
		if (pop) begin
			shift_q   <= shift_d;
			xs_q      <= xs_d;
			ys_q      <= ys_d;
			xe_q      <= xe_d;
			ye_q      <= ye_d;
			col_q     <= col_d;
			row_q     <= row_d;
			word_q    <= word_d;
			m_tdata_q <= {3'b000, rej, active_d, last, sda, vld};
			m_tuser_q <= dc;
			m_tlast_q <= done;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;
	assign m_tlast  = m_tlast_q;

endmodule

// File: rtl/slwf_checker.sv
// Port-level checks on the serializer output channel, bound to the top level.
`include "spi_lcd_window_fill_serializer_core_assert.svh"

module slwf_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata,
	input logic       m_tuser,
	input logic       m_tlast
);

	// A stalled output transaction holds its payload
	`SLWF_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "output changed while stalled")

	// Job end falls on a byte end and leaves the block idle
	`SLWF_ASSERT_NOW(a_done_shape, clk, arst_n, m_tvalid && m_tlast, m_tdata[0] && m_tdata[2] && !m_tdata[3], "job end without byte end or still busy")

	// With no bit out, line fields stay low
	`SLWF_ASSERT_NOW(a_idle_quiet, clk, arst_n, m_tvalid && !m_tdata[0], !m_tdata[1] && !m_tdata[2] && !m_tuser && !m_tlast && !m_tdata[3], "line fields active without a bit")

	// A rejected request only happens while a job is clocking out bits
	`SLWF_ASSERT_NOW(a_reject_busy, clk, arst_n, m_tvalid && m_tdata[4], m_tdata[0], "rejection while idle")

endmodule

bind spi_lcd_window_fill_serializer_core slwf_checker u_slwf_checker (.*);

// File: test/lcd_stream_checker.sv
// Checker for the SPI LCD window fill serializer: predicts each output transaction and compares.
module lcd_stream_checker import slwf_pkg::*; #(
	parameter int COORD_BITS = SLWF_COORD_BITS,
	parameter int DW         = ((4*COORD_BITS+16+7)/8)*8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	input  logic          s_tready,
	// x_start, y_start, x_end, y_end, value, zero fill
	input  logic [DW-1:0] s_tdata,
	// req_type
	input  logic [2:0]    s_tuser,
	input  logic          m_tvalid,
	input  logic          m_tready,
	// bit_valid, sda, byte_last, busy_res, rejected, zero fill
	input  logic [7:0]    m_tdata,
	// dc
	input  logic          m_tuser,
	input  logic          m_tlast,
	output int            fault_count,
	output int            due_count
);

	localparam int CB = COORD_BITS;

	typedef struct packed {
		logic bit_valid;
		logic sda;
		logic dc;
		logic byte_last;
		logic job_done;
		logic busy;
		logic rejected;
	} lcd_beat_t;

	// Expected output beats, oldest first
	lcd_beat_t beats_due[$];

	int faults = 0;
	int due    = 0;
	int beat_no;

	assign fault_count = faults;
	assign due_count   = due;

	// Shadow of the serializer's job state
	logic          run_on;
	logic [2:0]    kind;
	logic [7:0]    shreg;
	logic [2:0]    bit_no;
	logic [3:0]    hdr_pos;
	logic [CB-1:0] win_xs, win_ys, win_xe, win_ye;
	logic [CB-1:0] col, row;
	logic [15:0]   colour;
	logic          lo_pending;

	task automatic log_fault(input string msg);
		faults++;
		$display("[%0t] beat %0d mismatch: %s", $time, beat_no, msg);
	endtask

	task automatic check_field(input string name, input logic got, input logic want);
		if (got !== want)
			log_fault($sformatf("%s got %b want %b", name, got, want));
	endtask

	function automatic void clear_job_state();
		run_on     = 1'b0;
		kind       = REQ_TICK;
		shreg      = '0;
		bit_no     = '0;
		hdr_pos    = HDR_COL_CMD;
		win_xs     = '0;
		win_ys     = '0;
		win_xe     = '0;
		win_ye     = '0;
		col        = '0;
		row        = '0;
		colour     = '0;
		lo_pending = 1'b0;
	endfunction

	// Byte sent at a header position; coordinates zero-extended to 16 bits
	function automatic logic [7:0] window_header_byte(input logic [3:0] pos);
		logic [15:0] xs16, ys16, xe16, ye16;
		xs16 = '0;
		ys16 = '0;
		xe16 = '0;
		ye16 = '0;
		xs16[CB-1:0] = win_xs;
		ys16[CB-1:0] = win_ys;
		xe16[CB-1:0] = win_xe;
		ye16[CB-1:0] = win_ye;
		case (pos)
			HDR_COL_CMD: return CMD_COL_ADDR;
			HDR_XS_HI:   return xs16[15:8];
			HDR_XS_LO:   return xs16[7:0];
			HDR_XE_HI:   return xe16[15:8];
			HDR_XE_LO:   return xe16[7:0];
			HDR_ROW_CMD: return CMD_ROW_ADDR;
			HDR_YS_HI:   return ys16[15:8];
			HDR_YS_LO:   return ys16[7:0];
			HDR_YE_HI:   return ye16[15:8];
			HDR_YE_LO:   return ye16[7:0];
			default:     return CMD_MEM_WRITE;
		endcase
	endfunction

	// Load the following byte of the job; 1 means the job has finished
	function automatic logic load_next_byte();
		if (kind == REQ_WORD) begin
			if (lo_pending) begin
				shreg      = colour[7:0];
				lo_pending = 1'b0;
				return 1'b0;
			end
			return 1'b1;
		end
		if (kind != REQ_FILL)
			return 1'b1;
		if (hdr_pos < HDR_MEM_WR) begin
			hdr_pos = hdr_pos + 4'd1;
			shreg   = window_header_byte(hdr_pos);
			return 1'b0;
		end
		if (hdr_pos == HDR_MEM_WR) begin
			// memory write done; an empty window ends the job here
			hdr_pos = PIXEL_PHASE;
			if (win_xe < win_xs || win_ye < win_ys)
				return 1'b1;
		end else if (lo_pending) begin
			shreg      = colour[7:0];
			lo_pending = 1'b0;
			return 1'b0;
		end else if (col < win_xe) begin
			col = col + 1'b1;
		end else if (row < win_ye) begin
			row = row + 1'b1;
			col = win_xs;
		end else begin
			return 1'b1;
		end
		shreg      = colour[15:8];
		lo_pending = 1'b1;
		return 1'b0;
	endfunction

	// One tick of the serializer: accept or drop a job, then shift a bit out
	function automatic lcd_beat_t shift_out_bit(input logic [2:0] req, input logic [DW-1:0] d);
		lcd_beat_t b;
		logic      is_job;
		b      = '0;
		is_job = (req >= REQ_CMD) && (req <= REQ_FILL);
		if (is_job && run_on) begin
			b.rejected = 1'b1;
		end else if (is_job) begin
			kind       = req;
			bit_no     = '0;
			hdr_pos    = HDR_COL_CMD;
			lo_pending = 1'b0;
			run_on     = 1'b1;
			case (req)
				REQ_CMD, REQ_DATA: begin
					shreg = d[4*CB+7:4*CB];
				end
				REQ_WORD: begin
					colour     = d[4*CB+15:4*CB];
					shreg      = colour[15:8];
					lo_pending = 1'b1;
				end
				default: begin
					win_xs = d[CB-1:0];
					win_ys = d[2*CB-1:CB];
					win_xe = d[3*CB-1:2*CB];
					win_ye = d[4*CB-1:3*CB];
					col    = win_xs;
					row    = win_ys;
					colour = d[4*CB+15:4*CB];
					shreg  = CMD_COL_ADDR;
				end
			endcase
		end
		if (run_on) begin
			b.bit_valid = 1'b1;
			b.sda       = shreg[7];
			b.dc        = !(kind == REQ_CMD || (kind == REQ_FILL &&
				(hdr_pos == HDR_COL_CMD || hdr_pos == HDR_ROW_CMD || hdr_pos == HDR_MEM_WR)));
			b.byte_last = (bit_no == BIT_LAST);
			shreg       = shreg << 1;
			bit_no      = bit_no + 3'd1;
			if (b.byte_last && load_next_byte()) begin
				b.job_done = 1'b1;
				run_on     = 1'b0;
			end
		end
		b.busy = run_on;
		return b;
	endfunction

	// Predict on input transactions, compare on output transactions
	always @(posedge clk or negedge arst_n) begin : watch
		lcd_beat_t want;
		if (!arst_n) begin
			clear_job_state();
			beats_due.delete();
			due     = 0;
			beat_no = 0;
		end else begin
			if (s_tvalid === 1'b1 && s_tready === 1'b1)
				beats_due.push_back(shift_out_bit(s_tuser, s_tdata));
			if (m_tvalid === 1'b1 && m_tready === 1'b1) begin
				if (beats_due.size() == 0) begin
					log_fault("output transaction with nothing expected");
				end else begin
					want = beats_due.pop_front();
					check_field("bit_valid", m_tdata[0], want.bit_valid);
					check_field("sda", m_tdata[1], want.sda);
					check_field("byte_last", m_tdata[2], want.byte_last);
					check_field("busy_res", m_tdata[3], want.busy);
					check_field("rejected", m_tdata[4], want.rejected);
					check_field("dc", m_tuser, want.dc);
					check_field("job_done", m_tlast, want.job_done);
					if (m_tdata[7:5] !== 3'b000)
						log_fault($sformatf("m_tdata fill bits %b", m_tdata[7:5]));
				end
				beat_no++;
			end
			due = beats_due.size();
		end
	end

endmodule

// File: test/spi_lcd_window_fill_serializer_core_tb.sv
// Testbench top for the SPI LCD window fill serializer: stimulus, handshake idling and verdict.
module spi_lcd_window_fill_serializer_core_tb;
	import slwf_pkg::*;

	localparam int CB          = SLWF_COORD_BITS;
	localparam int DW          = ((4*CB+16+7)/8)*8;
	localparam int HEADER_BITS = 11 * 8;
	localparam int RANDOM_ITEMS = 240;
	// sender and receiver never idle within this stretch of items
	localparam int CALM_FROM   = 90;
	localparam int CALM_TO     = 190;
	// sender holds off here until every expected beat has arrived
	localparam int PAUSE_AT    = 40;
	// ~1.15k items, even with both sides idling, allowed for many times over
	localparam int LIMIT_TIME  = 2000000;

	// Request codes the block treats as a plain tick
	localparam logic [2:0] REQ_UNUSED_A = 3'd5;
	localparam logic [2:0] REQ_UNUSED_B = 3'd6;
	localparam logic [2:0] REQ_UNUSED_C = 3'd7;

	logic          clk;
	logic          arst_n;
	logic          s_tvalid;
	logic          s_tready;
	logic [DW-1:0] s_tdata;
	logic [2:0]    s_tuser;
	logic          m_tvalid;
	logic          m_tready;
	logic [7:0]    m_tdata;
	logic          m_tuser;
	logic          m_tlast;

	int   fault_count;
	int   due_count;
	int   bits_left;
	int   sent;
	logic calm;

	spi_lcd_window_fill_serializer_core #(.COORD_BITS(CB)) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	lcd_stream_checker #(.COORD_BITS(CB)) watch (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.m_tlast     (m_tlast),
		.fault_count (fault_count),
		.due_count   (due_count)
	);

	// Clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Hard stop
	initial begin
		#LIMIT_TIME;
		$display("Regression FAIL");
		$finish;
	end

	// Receiver stalls at random outside the calm stretch
	always @(negedge clk)
		m_tready <= calm || ($urandom_range(99) >= 24);

	function automatic logic [DW-1:0] pack_req(input logic [CB-1:0] xs, input logic [CB-1:0] ys,
		input logic [CB-1:0] xe, input logic [CB-1:0] ye, input logic [15:0] val);
		logic [DW-1:0] d;
		d = '0;
		d[CB-1:0]          = xs;
		d[2*CB-1:CB]       = ys;
		d[3*CB-1:2*CB]     = xe;
		d[4*CB-1:3*CB]     = ye;
		d[4*CB+15:4*CB]    = val;
		return d;
	endfunction

	function automatic logic [DW-1:0] random_data();
		return pack_req(CB'($urandom_range((1 << CB) - 1)), CB'($urandom_range((1 << CB) - 1)),
			CB'($urandom_range((1 << CB) - 1)), CB'($urandom_range((1 << CB) - 1)),
			16'($urandom_range(32'hFFFF)));
	endfunction

	// Serial bits a job sends
	function automatic int job_bits(input logic [2:0] req, input logic [DW-1:0] d);
		int w, h;
		case (req)
			REQ_CMD, REQ_DATA: return 8;
			REQ_WORD:          return 16;
			REQ_FILL: begin
				w = int'(d[3*CB-1:2*CB]) - int'(d[CB-1:0]) + 1;
				h = int'(d[4*CB-1:3*CB]) - int'(d[2*CB-1:CB]) + 1;
				if (w <= 0 || h <= 0)
					return HEADER_BITS;
				return HEADER_BITS + 16 * w * h;
			end
			default: return 0;
		endcase
	endfunction

	// Send one transaction; entered and left at a falling edge
	task automatic push_item(input logic [2:0] req, input logic [DW-1:0] d);
		while (!calm && $urandom_range(99) < 24) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= req;
		s_tdata  <= d;
		do @(posedge clk); while (s_tready !== 1'b1);
		@(negedge clk);
		// track how long the running job still needs ticks
		if (bits_left > 0)
			bits_left--;
		else if (req >= REQ_CMD && req <= REQ_FILL)
			bits_left = job_bits(req, d) - 1;
		sent++;
	endtask

	task automatic drain();
		while (bits_left > 0)
			push_item(REQ_TICK, random_data());
	endtask

	task automatic run_job(input logic [2:0] req, input logic [DW-1:0] d);
		push_item(req, d);
		drain();
	endtask

	// Random job; fills keep to small windows, some of them empty
	task automatic random_job();
		int            pick;
		logic [CB-1:0] xs, ys, xe, ye;
		pick = $urandom_range(99);
		xs   = CB'($urandom_range((1 << CB) - 1));
		ys   = CB'($urandom_range((1 << CB) - 1));
		xe   = CB'($urandom_range((1 << CB) - 1));
		ye   = CB'($urandom_range((1 << CB) - 1));
		if (pick < 20) begin
			push_item(REQ_CMD, pack_req(xs, ys, xe, ye, 16'($urandom_range(32'hFFFF))));
		end else if (pick < 40) begin
			push_item(REQ_DATA, pack_req(xs, ys, xe, ye, 16'($urandom_range(32'hFFFF))));
		end else if (pick < 65) begin
			push_item(REQ_WORD, pack_req(xs, ys, xe, ye, 16'($urandom_range(32'hFFFF))));
		end else begin
			xe = xs + CB'($urandom_range(2));
			if (xe < xs)
				xe = '1;
			ye = ys + CB'($urandom_range(1));
			if (ye < ys)
				ye = '1;
			pick = $urandom_range(9);
			if (pick == 0) begin
				if (xs == 0)
					xs = CB'(1);
				xe = CB'($urandom_range(32'(xs) - 32'd1));
			end else if (pick == 1) begin
				if (ys == 0)
					ys = CB'(1);
				ye = CB'($urandom_range(32'(ys) - 32'd1));
			end
			push_item(REQ_FILL, pack_req(xs, ys, xe, ye, 16'($urandom_range(32'hFFFF))));
		end
	endtask

	// Stimulus and verdict
	initial begin : stimulus
		int         roll;
		int         target;
		logic [2:0] odd_code;
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = REQ_TICK;
		calm      = 1'b0;
		bits_left = 0;
		sent      = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Idle ticks, including the unused codes, with every data bit set
		push_item(REQ_TICK, pack_req('1, '1, '1, '1, 16'hFFFF));
		push_item(REQ_UNUSED_A, random_data());
		push_item(REQ_UNUSED_B, random_data());
		push_item(REQ_UNUSED_C, pack_req('1, '1, '1, '1, 16'hFFFF));

		// Bytes and words at the extremes; only the low byte counts for a byte
		run_job(REQ_CMD, pack_req('0, '0, '0, '0, 16'hFF00));
		run_job(REQ_CMD, pack_req('1, '1, '1, '1, 16'h00FF));
		run_job(REQ_DATA, pack_req('0, '0, '0, '0, 16'h5AA5));
		run_job(REQ_DATA, pack_req('1, '1, '1, '1, 16'hFFFF));
		run_job(REQ_WORD, pack_req('0, '0, '0, '0, 16'h0000));
		run_job(REQ_WORD, pack_req('1, '1, '1, '1, 16'hFFFF));
		run_job(REQ_WORD, pack_req('0, '0, '0, '0, 16'h8001));

		// Fills: single pixel at both corners, a square, a run over the 255 boundary, a pair at the far edge
		run_job(REQ_FILL, pack_req('0, '0, '0, '0, 16'hF800));
		run_job(REQ_FILL, pack_req('1, '1, '1, '1, 16'h07E0));
		run_job(REQ_FILL, pack_req(9'd255, 9'd256, 9'd256, 9'd257, 16'h001F));
		run_job(REQ_FILL, pack_req(9'd255, 9'd3, 9'd257, 9'd3, 16'hA5C3));
		run_job(REQ_FILL, pack_req(9'd510, 9'd511, 9'd511, 9'd511, 16'h3C5A));

		// Empty windows: header and memory write only
		run_job(REQ_FILL, pack_req(9'd511, 9'd0, 9'd0, 9'd511, 16'hFFFF));
		run_job(REQ_FILL, pack_req(9'd0, 9'd200, 9'd511, 9'd199, 16'h1234));

		// Requests while busy are dropped, the job keeps shifting
		push_item(REQ_WORD, pack_req('0, '0, '0, '0, 16'hC33C));
		push_item(REQ_FILL, random_data());
		push_item(REQ_CMD, random_data());
		push_item(REQ_DATA, random_data());
		push_item(REQ_WORD, random_data());
		push_item(REQ_UNUSED_B, random_data());
		drain();

		// A request on the final bit is still dropped; the next one is taken
		push_item(REQ_CMD, pack_req('0, '0, '0, '0, 16'h002C));
		repeat (6) push_item(REQ_TICK, random_data());
		push_item(REQ_DATA, random_data());
		run_job(REQ_DATA, pack_req('0, '0, '0, '0, 16'h0081));

		// Random part: mostly whole jobs fed with ticks, some dropped requests and noise
		target = sent + RANDOM_ITEMS;
		while (sent < target) begin
			roll = target - sent;
			calm = (RANDOM_ITEMS - roll >= CALM_FROM) && (RANDOM_ITEMS - roll < CALM_TO);
			if (RANDOM_ITEMS - roll == PAUSE_AT) begin
				s_tvalid <= 1'b0;
				while (due_count != 0)
					@(negedge clk);
				@(negedge clk);
			end
			roll     = $urandom_range(99);
			odd_code = 3'($urandom_range(32'(REQ_UNUSED_A), 32'(REQ_UNUSED_C)));
			if (bits_left == 0) begin
				if (roll < 85)
					random_job();
				else if (roll < 95)
					push_item(REQ_TICK, random_data());
				else
					push_item(odd_code, random_data());
			end else begin
				if (roll < 92)
					push_item(REQ_TICK, random_data());
				else if (roll < 97)
					random_job();
				else
					push_item(odd_code, random_data());
			end
		end
		calm = 1'b0;

		// Wait out the outstanding beats, then the pipeline latency
		s_tvalid <= 1'b0;
		while (due_count != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
		if (fault_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
